// ----- rtl/core/camera_lookat_basis_defines.svh -----
// Assertion macros for the look-at basis block.
// Used by files that carry concurrent checks; depends on clk_i and rst_ni in scope.
`ifndef CAMERA_LOOKAT_BASIS_DEFINES_SVH
`define CAMERA_LOOKAT_BASIS_DEFINES_SVH

// Property that holds in the same cycle.
`define CLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the next cycle.
`define CLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/clb_pkg.sv -----
// Shared constants for the look-at basis block.
// No dependencies.
package clb_pkg;
  localparam int FracBitsDef = 16;
  localparam int InW         = 32;
  localparam int OutW        = 18;
endpackage

// ----- rtl/core/clb_stream_if.sv -----
// Valid/ready stream interfaces for the look-at basis block.
// Depends on clb_pkg for field widths.
interface clb_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [clb_pkg::InW-1:0]   center_x, center_y, center_z;
  logic signed [clb_pkg::InW-1:0]   target_x, target_y, target_z;
  logic signed [clb_pkg::InW-1:0]   hint_up_x, hint_up_y, hint_up_z;

  modport source (output valid, center_x, center_y, center_z, target_x, target_y, target_z,
                  hint_up_x, hint_up_y, hint_up_z, input ready);
  modport sink   (input valid, center_x, center_y, center_z, target_x, target_y, target_z,
                  hint_up_x, hint_up_y, hint_up_z, output ready);
endinterface

interface clb_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [clb_pkg::OutW-1:0]  right_x, right_y, right_z;
  logic signed [clb_pkg::OutW-1:0]  up_x, up_y, up_z;
  logic signed [clb_pkg::OutW-1:0]  front_x, front_y, front_z;
  logic                             degenerate;

  modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  front_x, front_y, front_z, degenerate, input ready);
  modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  front_x, front_y, front_z, degenerate, output ready);
endinterface

// ----- rtl/core/clb_normalize.sv -----
// Pipelined three-lane vector normalizer with rounding to nearest.
// Standalone; stage enable comes from the top level.
module clb_normalize #(
  parameter int W  = 33,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  vec_i [3],
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic                 ok_o,
  output logic signed [F+1:0]  unit_o [3],
  output logic [SW-1:0]        side_o
);
  localparam int RW  = 2*F + 70;
  localparam int NI  = F + 2;
  localparam int SHW = $clog2(W + 1);

  // Magnitudes and the common right shift that brings them below 2^31.
  logic [W-1:0]   mag [3];
  logic [W-1:0]   any_bits;
  logic [SHW-1:0] sh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    any_bits = mag[0] | mag[1] | mag[2];
    sh = '0;
    for (int b = 31; b < W; b++) begin
      if (any_bits[b]) sh = SHW'(b - 30);
    end
  end

  logic          v0_q, v1_q;
  logic [30:0]   m0_q  [3];
  logic [61:0]   sq1_q [3];
  logic [2:0]    neg0_q, neg1_q;
  logic          nz0_q, nz1_q;
  logic [SW-1:0] sd0_q, sd1_q;

  // Iteration stage registers; index 0 is the initial remainder.
  logic                 vs_q  [NI];
  logic signed [RW-1:0] r_q   [NI][3];
  logic signed [RW-1:0] ts_q  [NI][3];
  logic [F:0]           qv_q  [NI][3];
  logic [63:0]          s_q   [NI];
  logic [2:0]           neg_q [NI];
  logic                 nz_q  [NI];
  logic [SW-1:0]        sd_q  [NI];

  // Front stages: valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      vs_q[0]  <= 1'b0;
    end else if (en_i) begin
      v0_q     <= valid_i;
      v1_q     <= v0_q;
      vs_q[0]  <= v1_q;
    end
  end

  // Front stages: shift, square, sum of squares and initial remainder.
  logic [63:0] s_sum;
  assign s_sum = 64'(sq1_q[0]) + 64'(sq1_q[1]) + 64'(sq1_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m0_q[i]  <= 31'(mag[i] >> sh);
        neg0_q[i] <= vec_i[i][W-1];
        sq1_q[i] <= 62'(m0_q[i]) * 62'(m0_q[i]);
        r_q[0][i]  <= (RW'(sq1_q[i]) << (2*F + 2)) - RW'(s_sum);
        ts_q[0][i] <= -$signed(RW'(s_sum));
        qv_q[0][i] <= '0;
      end
      nz0_q    <= |any_bits;
      sd0_q    <= side_i;
      neg1_q   <= neg0_q;
      nz1_q    <= nz0_q;
      sd1_q    <= sd0_q;
      s_q[0]   <= s_sum;
      neg_q[0] <= neg1_q;
      nz_q[0]  <= nz1_q;
      sd_q[0]  <= sd1_q;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < NI - 1; j++) begin : g_iter
    localparam int K = F - j;
    logic signed [RW-1:0] rn [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rn[l] = r_q[j][l] - ((ts_q[j][l] <<< (K + 2)) + $signed(RW'(s_q[j]) << (2*K + 2)));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vs_q[j+1] <= vs_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 3; l++) begin
          if (!rn[l][RW-1]) begin
            r_q[j+1][l]  <= rn[l];
            ts_q[j+1][l] <= ts_q[j][l] + $signed(RW'(s_q[j]) << (K + 1));
            qv_q[j+1][l] <= qv_q[j][l] | ((F+1)'(1) << K);
          end else begin
            r_q[j+1][l]  <= r_q[j][l];
            ts_q[j+1][l] <= ts_q[j][l];
            qv_q[j+1][l] <= qv_q[j][l];
          end
        end
        s_q[j+1]   <= s_q[j];
        neg_q[j+1] <= neg_q[j];
        nz_q[j+1]  <= nz_q[j];
        sd_q[j+1]  <= sd_q[j];
      end
    end
  end

  // Apply the component signs.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unit_o[l] = neg_q[NI-1][l] ? -$signed({1'b0, qv_q[NI-1][l]})
                                 : $signed({1'b0, qv_q[NI-1][l]});
    end
  end

  assign valid_o = vs_q[NI-1];
  assign ok_o    = nz_q[NI-1];
  assign side_o  = sd_q[NI-1];
endmodule

// ----- rtl/core/camera_lookat_basis.sv -----
// Top level of the look-at basis block: front, up and right unit axes.
// Depends on clb_pkg, clb_stream_if, clb_normalize and the defines header.
//
// Usage: each transfer on in_i carries a camera center, a target and a
// provisional up vector in signed fixed point with FRAC_BITS fraction bits.
// Each transfer on out_o carries the right, up and front unit vectors with
// the same fraction bits, rounded to nearest, and a degenerate flag. When
// the view direction, the orthogonalized up or the right axis has zero
// length, degenerate is set and all nine components are zero.
// The pipeline is three normalizers of FRAC_BITS + 4 stages each, a depth
// set by one quotient bit per stage, plus the projection and cross product
// stages and the output register. Throughput is one transfer per cycle
// while the receiver does not stall. The pipeline advances as a whole
// while the output register is empty or being taken; when the receiver
// stalls, every stage holds and in_i.ready drops, so nothing is lost or
// repeated. Reset clears the valid bits only; the block keeps no state
// between items.
`include "camera_lookat_basis_defines.svh"

module camera_lookat_basis #(
  parameter int FRAC_BITS = clb_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clb_in_if.sink     in_i,
  clb_out_if.source  out_o
);
  localparam int F    = FRAC_BITS;
  localparam int UNW  = F + 2;
  localparam int PW   = clb_pkg::InW + UNW;
  localparam int DW   = PW + 2;
  localparam int DRW  = 37;
  localparam int PRW  = DRW + UNW;
  localparam int UW   = 36;
  localparam int CPW  = 2*UNW;
  localparam int CW   = CPW + 1;
  localparam int HSW  = 3*clb_pkg::InW;
  localparam int FSW  = 3*UNW + 1;
  localparam int USW  = 6*UNW + 1;
  localparam int OW   = clb_pkg::OutW;

  logic en;
  logic out_valid_q;
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // View direction, exact difference.
  logic signed [32:0] dvec [3];
  assign dvec[0] = 33'(in_i.target_x) - 33'(in_i.center_x);
  assign dvec[1] = 33'(in_i.target_y) - 33'(in_i.center_y);
  assign dvec[2] = 33'(in_i.target_z) - 33'(in_i.center_z);

  logic                     n1_valid, n1_ok;
  logic signed [UNW-1:0]    f1 [3];
  logic [HSW-1:0]           n1_side;

  clb_normalize #(.W(33), .F(F), .SW(HSW)) u_norm_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .vec_i   (dvec),
    .side_i  ({in_i.hint_up_x, in_i.hint_up_y, in_i.hint_up_z}),
    .valid_o (n1_valid),
    .ok_o    (n1_ok),
    .unit_o  (f1),
    .side_o  (n1_side)
  );

  logic signed [clb_pkg::InW-1:0] h1 [3];
  assign h1[0] = n1_side[HSW-1 -: clb_pkg::InW];
  assign h1[1] = n1_side[2*clb_pkg::InW-1 -: clb_pkg::InW];
  assign h1[2] = n1_side[clb_pkg::InW-1:0];

  // Projection stages: products, rounded dot, scaled front.
  logic                           p1_v_q, p2_v_q, p3_v_q;
  logic                           p1_ok_q, p2_ok_q, p3_ok_q;
  logic signed [PW-1:0]           prod_q [3];
  logic signed [DRW-1:0]          dot_q;
  logic signed [PRW-1:0]          pr_q [3];
  logic signed [UNW-1:0]          f_p1_q [3], f_p2_q [3], f_p3_q [3];
  logic signed [clb_pkg::InW-1:0] h_p1_q [3], h_p2_q [3], h_p3_q [3];

  logic signed [DW-1:0] dot_sum, dot_mag, dot_rm;
  assign dot_sum = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
  assign dot_mag = dot_sum[DW-1] ? -dot_sum : dot_sum;
  assign dot_rm  = (dot_mag + (DW'(1) <<< (F - 1))) >>> F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= n1_valid;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= PW'(h1[i]) * PW'(f1[i]);
        pr_q[i]   <= PRW'(dot_q) * PRW'(f_p2_q[i]);
        f_p1_q[i] <= f1[i];
        f_p2_q[i] <= f_p1_q[i];
        f_p3_q[i] <= f_p2_q[i];
        h_p1_q[i] <= h1[i];
        h_p2_q[i] <= h_p1_q[i];
        h_p3_q[i] <= h_p2_q[i];
      end
      dot_q   <= dot_sum[DW-1] ? -dot_rm[DRW-1:0] : dot_rm[DRW-1:0];
      p1_ok_q <= n1_ok;
      p2_ok_q <= p1_ok_q;
      p3_ok_q <= p2_ok_q;
    end
  end

  // Orthogonalized up: hint minus the rounded projection.
  logic signed [PRW-1:0] pr_mag [3], pr_rm [3];
  logic signed [UW-1:0]  uvec [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_mag[i] = pr_q[i][PRW-1] ? -pr_q[i] : pr_q[i];
      pr_rm[i]  = (pr_mag[i] + (PRW'(1) <<< (F - 1))) >>> F;
      uvec[i]   = UW'(h_p3_q[i]) - (pr_q[i][PRW-1] ? -pr_rm[i][UW-1:0] : pr_rm[i][UW-1:0]);
    end
  end

  logic                  n2_valid, n2_ok;
  logic signed [UNW-1:0] u2 [3];
  logic [FSW-1:0]        n2_side;

  clb_normalize #(.W(UW), .F(F), .SW(FSW)) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3_v_q),
    .vec_i   (uvec),
    .side_i  ({f_p3_q[0], f_p3_q[1], f_p3_q[2], p3_ok_q}),
    .valid_o (n2_valid),
    .ok_o    (n2_ok),
    .unit_o  (u2),
    .side_o  (n2_side)
  );

  logic signed [UNW-1:0] f2 [3];
  assign f2[0] = n2_side[FSW-1 -: UNW];
  assign f2[1] = n2_side[2*UNW -: UNW];
  assign f2[2] = n2_side[UNW:1];

  // Cross product up x front, exact.
  logic                  c1_v_q, c1_ok_q;
  logic signed [CPW-1:0] cp_q [6];
  logic signed [UNW-1:0] u_c1_q [3], f_c1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
    end else if (en) begin
      c1_v_q <= n2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0] <= CPW'(u2[1]) * CPW'(f2[2]);
      cp_q[1] <= CPW'(u2[2]) * CPW'(f2[1]);
      cp_q[2] <= CPW'(u2[2]) * CPW'(f2[0]);
      cp_q[3] <= CPW'(u2[0]) * CPW'(f2[2]);
      cp_q[4] <= CPW'(u2[0]) * CPW'(f2[1]);
      cp_q[5] <= CPW'(u2[1]) * CPW'(f2[0]);
      u_c1_q  <= u2;
      f_c1_q  <= f2;
      c1_ok_q <= n2_side[0] && n2_ok;
    end
  end

  logic signed [CW-1:0] cvec [3];
  assign cvec[0] = CW'(cp_q[0]) - CW'(cp_q[1]);
  assign cvec[1] = CW'(cp_q[2]) - CW'(cp_q[3]);
  assign cvec[2] = CW'(cp_q[4]) - CW'(cp_q[5]);

  logic                  n3_valid, n3_ok;
  logic signed [UNW-1:0] r3 [3];
  logic [USW-1:0]        n3_side;

  clb_normalize #(.W(CW), .F(F), .SW(USW)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c1_v_q),
    .vec_i   (cvec),
    .side_i  ({u_c1_q[0], u_c1_q[1], u_c1_q[2], f_c1_q[0], f_c1_q[1], f_c1_q[2], c1_ok_q}),
    .valid_o (n3_valid),
    .ok_o    (n3_ok),
    .unit_o  (r3),
    .side_o  (n3_side)
  );

  // Output register; a degenerate item reports all zero components.
  logic                 deg;
  logic signed [OW-1:0] res [9];
  assign deg = !(n3_ok && n3_side[0]);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i]   = deg ? '0 : OW'(r3[i]);
      res[3+i] = deg ? '0 : OW'($signed(n3_side[USW-1-UNW*i -: UNW]));
      res[6+i] = deg ? '0 : OW'($signed(n3_side[USW-1-UNW*(3+i) -: UNW]));
    end
  end

  logic signed [OW-1:0] res_q [9];
  logic                 deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= n3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res;
      deg_q <= deg;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.right_x    = res_q[0];
  assign out_o.right_y    = res_q[1];
  assign out_o.right_z    = res_q[2];
  assign out_o.up_x       = res_q[3];
  assign out_o.up_y       = res_q[4];
  assign out_o.up_z       = res_q[5];
  assign out_o.front_x    = res_q[6];
  assign out_o.front_y    = res_q[7];
  assign out_o.front_z    = res_q[8];
  assign out_o.degenerate = deg_q;

  // A degenerate result has zero right_x, up_x, front_x and front_z components.
  `CLB_ASSERT(a_deg_zero, !(out_valid_q && deg_q) || (res_q[0] == 0 && res_q[3] == 0 && res_q[6] == 0 && res_q[8] == 0), "degenerate result with nonzero component")
  // A good result always has a nonzero front axis.
  `CLB_ASSERT(a_front_nz, !(out_valid_q && !deg_q) || (res_q[6] != 0 || res_q[7] != 0 || res_q[8] != 0), "good result with zero front axis")
  // An advancing cycle without a valid front normalizer output leaves a bubble in the first projection stage.
  `CLB_ASSERT_NEXT(a_bubble, en && !n1_valid, !p1_v_q, "projection stage valid without source")
endmodule
